// File: src/rcfr_pkg.sv
// Package for the serial RC frame receiver: payload structs, codes and
// reset constants. No dependencies.
`timescale 1ns / 1ps

package rcfr_pkg;

  // Default channel count, reset values of the registers and timer saturation value
  localparam int          CHANNELS_DEF = 10;
  localparam logic [7:0]  SYNC_RST     = 8'h20;
  localparam logic [7:0]  GAP_RST      = 8'd3;
  localparam logic [7:0]  FAILSAFE_RST = 8'd156;
  localparam logic [15:0] SUM_INIT     = 16'hFFFF;
  localparam logic [7:0]  TICK_MAX     = 8'hFF;

  // Request codes
  typedef enum logic [1:0] {
    REQ_BYTE = 2'd0,
    REQ_TICK = 2'd1,
    REQ_READ = 2'd2
  } req_t;

  // Read status codes
  localparam logic [1:0] ST_VALID   = 2'd0;
  localparam logic [1:0] ST_NEVER   = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  // Frame result codes
  localparam logic [1:0] FR_NONE = 2'd0;
  localparam logic [1:0] FR_GOOD = 2'd1;
  localparam logic [1:0] FR_BAD  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_SYNC     = 2'd0;
  localparam logic [1:0] CFG_GAP      = 2'd1;
  localparam logic [1:0] CFG_FAILSAFE = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
    logic [3:0] channel_index;
  } rcfr_in_t;

  typedef struct packed {
    logic [15:0] read_value;
    logic [1:0]  read_status;
    logic [1:0]  frame_result;
    logic [5:0]  bytes_to_frame_end;
  } rcfr_out_t;

  // Framer report for the current transaction
  typedef struct packed {
    logic       commit;
    logic [1:0] frame_result;
    logic [5:0] to_end;
  } rcfr_ev_t;

endpackage

// File: src/rcfr_framer.sv
// Frame assembler: sync detection, byte position, running checksum, gap
// timer and staging of channel bytes. Depends on rcfr_pkg.
`timescale 1ns / 1ps

module rcfr_framer import rcfr_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_en,
  input  logic        tick_en,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  sync_value,
  input  logic [7:0]  gap_limit,
  output rcfr_ev_t    ev,
  output logic [15:0] stage [CHANNELS]
);

  localparam int         IDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [5:0] FRAME_LEN = 6'(2 * CHANNELS + 12);
  localparam logic [5:0] DATA_END  = 6'(2 * CHANNELS + 2);
  localparam logic [5:0] POS_FIRST = 6'd2;

  logic [5:0]  pos_r, pos_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  gap_r, gap_nxt, gap_inc;
  logic [7:0]  cks_lo_r, cks_lo_nxt;
  logic        stage_we;
  logic [5:0]  data_off;
  logic [IDX_W-1:0] stage_idx;

  assign data_off  = pos_r - POS_FIRST;
  assign stage_idx = data_off[IDX_W:1];
  assign gap_inc   = (gap_r == TICK_MAX) ? gap_r : gap_r + 8'd1;

  // Next framing state for this transaction
  always_comb begin
    pos_nxt         = pos_r;
    sum_nxt         = sum_r;
    gap_nxt         = gap_r;
    cks_lo_nxt      = cks_lo_r;
    stage_we        = 1'b0;
    ev.commit       = 1'b0;
    ev.frame_result = FR_NONE;
    if (byte_en) begin
      gap_nxt = 8'd0;
      if (!(pos_r == 6'd0 && rx_byte != sync_value)) begin
        if (pos_r == FRAME_LEN - 6'd1) begin
          // last checksum byte: compare and restart
          ev.commit       = ({rx_byte, cks_lo_r} == sum_r);
          ev.frame_result = ev.commit ? FR_GOOD : FR_BAD;
          pos_nxt         = 6'd0;
          sum_nxt         = SUM_INIT;
        end else begin
          pos_nxt = pos_r + 6'd1;
          if (pos_r <= FRAME_LEN - 6'd3) sum_nxt = sum_r - {8'd0, rx_byte};
          if (pos_r == FRAME_LEN - 6'd2) cks_lo_nxt = rx_byte;
          stage_we = (pos_r >= POS_FIRST) && (pos_r < DATA_END);
        end
      end
    end else if (tick_en) begin
      gap_nxt = gap_inc;
      if (gap_inc > gap_limit) begin
        pos_nxt = 6'd0;
        sum_nxt = SUM_INIT;
      end
    end
    ev.to_end = FRAME_LEN - pos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 6'd0;
      sum_r <= SUM_INIT;
      gap_r <= 8'd0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
      gap_r <= gap_nxt;
    end
  end

  // Payload: checksum low byte and channel staging (little-endian)
  always_ff @(posedge clk) begin
    cks_lo_r <= cks_lo_nxt;
    if (stage_we) begin
      if (data_off[0]) stage[stage_idx][15:8] <= rx_byte;
      else             stage[stage_idx][7:0]  <= rx_byte;
    end
  end

endmodule

// File: src/rcfr_chan_store.sv
// Channel store: committed values, channel status, failsafe timer and the
// read path. Depends on rcfr_pkg.
`timescale 1ns / 1ps

module rcfr_chan_store import rcfr_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        tick_en,
  input  logic        commit,
  input  logic [15:0] stage [CHANNELS],
  input  logic [7:0]  failsafe_limit,
  input  logic        read_en,
  input  logic [3:0]  channel_index,
  output logic [15:0] read_value,
  output logic [1:0]  read_status
);

  localparam int         IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [3:0] CH_N  = 4'(CHANNELS);

  logic [15:0] values_r [CHANNELS];
  logic [1:0]  state_r, state_nxt;
  logic [7:0]  fs_r, fs_nxt, fs_inc;

  assign fs_inc = (fs_r == TICK_MAX) ? fs_r : fs_r + 8'd1;

  // Status and failsafe update
  always_comb begin
    state_nxt = state_r;
    fs_nxt    = fs_r;
    if (commit) begin
      state_nxt = ST_VALID;
      fs_nxt    = 8'd0;
    end else if (tick_en) begin
      fs_nxt = fs_inc;
      if (fs_inc > failsafe_limit) state_nxt = ST_TIMEOUT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_NEVER;
      fs_r    <= 8'd0;
    end else begin
      state_r <= state_nxt;
      fs_r    <= fs_nxt;
    end
  end

  // Commit copies all staged channels at once
  always_ff @(posedge clk) begin
    if (commit) values_r <= stage;
  end

  // Read path
  always_comb begin
    read_value  = 16'd0;
    read_status = ST_VALID;
    if (read_en) begin
      if (channel_index >= CH_N) begin
        read_status = ST_RANGE;
      end else begin
        read_status = state_r;
        if (state_r == ST_VALID) read_value = values_r[channel_index[IDX_W-1:0]];
      end
    end
  end

endmodule

// File: src/rc_serial_frame_receiver.sv
// Top level of the serial RC frame receiver: handshakes, configuration
// registers and result register. Depends on rcfr_pkg, rcfr_framer, rcfr_chan_store.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_stall/in_data) carries one request per
//   transaction: a received byte, a timer tick or a channel read. Every
//   request yields exactly one result on the output channel
//   (out_valid/out_stall/out_data): read value and status, frame result and
//   bytes still missing to the end of the frame.
//   The result is registered: it appears in the output register on the
//   edge after the request is taken. Throughput is one request per cycle
//   while the output is not stalled; all work is a single pass of logic
//   between the input port and the result register.
//   When the receiver stalls, the result holds and in_stall is raised only
//   while the output register is full and stalled, so a new request is taken
//   in the same cycle the old result leaves.
//   Reset (synchronous, rst_n low) restores register defaults, restarts
//   framing and marks all channels as never received; no clearing pass.
//   Configuration writes (cfg_valid/cfg_ready, always ready) go to sync
//   value, gap limit and failsafe limit; write them only while idle.
module rc_serial_frame_receiver import rcfr_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  rcfr_in_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output rcfr_out_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic [7:0]  sync_r, gap_lim_r, fs_lim_r;
  logic        out_valid_r;
  rcfr_out_t   out_data_r, out_nxt;
  logic        take;
  logic        byte_en, tick_en, read_en;
  rcfr_ev_t    ev;
  logic [15:0] stage [CHANNELS];
  logic [15:0] read_value;
  logic [1:0]  read_status;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r    <= SYNC_RST;
      gap_lim_r <= GAP_RST;
      fs_lim_r  <= FAILSAFE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SYNC:     sync_r    <= cfg_data;
        CFG_GAP:      gap_lim_r <= cfg_data;
        CFG_FAILSAFE: fs_lim_r  <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Input handshake and request decode
  assign in_stall = out_valid_r && out_stall;
  assign take     = in_valid && !in_stall;
  assign byte_en  = take && (in_data.req_type == REQ_BYTE);
  assign tick_en  = take && (in_data.req_type == REQ_TICK);
  assign read_en  = take && (in_data.req_type == REQ_READ);

  rcfr_framer #(.CHANNELS(CHANNELS)) u_framer (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_en    (byte_en),
    .tick_en    (tick_en),
    .rx_byte    (in_data.rx_byte),
    .sync_value (sync_r),
    .gap_limit  (gap_lim_r),
    .ev         (ev),
    .stage      (stage)
  );

  rcfr_chan_store #(.CHANNELS(CHANNELS)) u_store (
    .clk            (clk),
    .rst_n          (rst_n),
    .tick_en        (tick_en),
    .commit         (ev.commit),
    .stage          (stage),
    .failsafe_limit (fs_lim_r),
    .read_en        (read_en),
    .channel_index  (in_data.channel_index),
    .read_value     (read_value),
    .read_status    (read_status)
  );

  // Result register
  always_comb begin
    out_nxt.read_value         = read_value;
    out_nxt.read_status        = read_status;
    out_nxt.frame_result       = ev.frame_result;
    out_nxt.bytes_to_frame_end = ev.to_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
